>>> design/graph_bridge_finder_unit_macros.svh
// Assertion macros used by the checker of the bridge finder.
`ifndef GRAPH_BRIDGE_FINDER_UNIT_MACROS_SVH
`define GRAPH_BRIDGE_FINDER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gbf_pkg.sv
`timescale 1ns / 1ps

package gbf_pkg;

  // Default capacities
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 4096;

  // Fixed field widths of the word ports
  localparam int REQ_W   = 2;
  localparam int VTX_W   = 10;
  localparam int QEDGE_W = 12;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 10;
  localparam int CFG_W   = 11;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADVTX  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTLOAD = 2'd3;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_QRY,
    S_CLR,
    S_DEG_RD,
    S_DEG_A,
    S_DEG_AW,
    S_DEG_BR,
    S_DEG_BW,
    S_PRE_RD,
    S_PRE_WR,
    S_PRE_END,
    S_FIL_RD,
    S_FIL_A,
    S_FIL_AW,
    S_FIL_BR,
    S_FIL_BW,
    S_ROOT,
    S_ROOT_CHK,
    S_ENT_RD0,
    S_ENT_RD1,
    S_ENT_SET,
    S_TOP,
    S_ADJ,
    S_VIS,
    S_POP_RD,
    S_POP_SET,
    S_DONE
  } state_t;

endpackage

>>> design/gbf_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one registered read port.
module gbf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/graph_bridge_finder_unit.sv
`timescale 1ns / 1ps

// Bridge finder for an undirected multigraph.
// Input channel (in_valid / in_stall): one request word per item: clear,
// add edge (in_end_a, in_end_b), run search, or query edge (in_query_edge).
// Result channel (out_valid / out_stall): exactly one word per request with
// status, assigned edge, bridge flag and the bridge count of the last run.
// cfg_wr_en / cfg_vertex_count sets the vertex count; the user must write
// it only while idle, the block does not enforce this. Clear, add and a
// query of an absent edge answer in the cycle after acceptance; a query
// of a loaded edge first reads its flag in S_QRY. A run is walked by one
// sequencer over single-port reads of the edge, adjacency and per-vertex RAMs.
// One request is in flight at a time; in_stall is high while the sequencer
// works or a result word waits, so the next word can be taken in the cycle
// after the result leaves. A stalled result word holds its value.
// Reset empties the edge table, zeroes the bridge count and sets the vertex
// count to 1; no clearing pass is needed.
module graph_bridge_finder_unit #(
  parameter int MAX_VERTICES = gbf_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gbf_pkg::MAX_EDGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [gbf_pkg::CFG_W-1:0]    cfg_vertex_count,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gbf_pkg::REQ_W-1:0]    in_req_type,
  input  logic [gbf_pkg::VTX_W-1:0]    in_end_a,
  input  logic [gbf_pkg::VTX_W-1:0]    in_end_b,
  input  logic [gbf_pkg::QEDGE_W-1:0]  in_query_edge,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gbf_pkg::STAT_W-1:0]   out_status,
  output logic [gbf_pkg::QEDGE_W-1:0]  out_assigned_edge,
  output logic                         out_is_bridge,
  output logic [gbf_pkg::CNT_W-1:0]    out_bridge_count
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LW = $clog2(MAX_EDGES + 1);
  localparam int XW = $clog2(2 * MAX_EDGES);
  localparam int PW = $clog2(2 * MAX_EDGES + 1);
  localparam logic [LW-1:0] NO_EDGE = LW'(MAX_EDGES);

  gbf_pkg::state_t state_r, state_nxt;

  // Control and datapath registers
  logic                        out_valid_r, out_valid_nxt;
  logic [gbf_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [gbf_pkg::QEDGE_W-1:0] out_assigned_r, out_assigned_nxt;
  logic                        out_bridge_r, out_bridge_nxt;
  logic [gbf_pkg::CNT_W-1:0]   out_count_r, out_count_nxt;
  logic [gbf_pkg::CFG_W-1:0]   vcount_r;
  logic [LW-1:0]               loaded_r, loaded_nxt;
  logic [gbf_pkg::CNT_W-1:0]   bridges_r, bridges_nxt;
  logic [gbf_pkg::QEDGE_W-1:0] q_r, q_nxt;
  logic [CW-1:0]               vcnt_r, vcnt_nxt;
  logic [LW-1:0]               ecnt_r, ecnt_nxt;
  logic [PW-1:0]               total_r, total_nxt;
  logic [VW-1:0]               a_r, a_nxt, b_r, b_nxt;
  logic [CW-1:0]               root_r, root_nxt;
  logic [VW-1:0]               timer_r, timer_nxt;
  logic [CW-1:0]               depth_r, depth_nxt;
  logic [VW-1:0]               v_r, v_nxt, w_r, w_nxt, u_r, u_nxt;
  logic [PW-1:0]               pos_r, pos_nxt, end_r, end_nxt;
  logic [PW-1:0]               wstart_r, wstart_nxt, upos_r, upos_nxt;
  logic [VW-1:0]               low_r, low_nxt;
  logic [LW-1:0]               par_r, par_nxt, e_r, e_nxt;

  // RAM ports
  logic          edge_we;
  logic [EW-1:0] edge_waddr, edge_raddr;
  logic [VW-1:0] ea_wdata, eb_wdata, ea_rdata, eb_rdata;
  logic          flag_we, flag_wdata, flag_rdata;
  logic [EW-1:0] flag_waddr, flag_raddr;
  logic          start_we;
  logic [CW-1:0] start_waddr, start_raddr;
  logic [PW-1:0] start_wdata, start_rdata;
  logic          fill_we;
  logic [VW-1:0] fill_waddr, fill_raddr;
  logic [PW-1:0] fill_wdata, fill_rdata;
  logic          adj_we;
  logic [XW-1:0] adj_waddr, adj_raddr;
  logic [VW+EW-1:0] adj_wdata, adj_rdata;
  logic          vis_we, vis_wdata, vis_rdata;
  logic [VW-1:0] vis_waddr, vis_raddr;
  logic          ent_we;
  logic [VW-1:0] ent_waddr, ent_raddr, ent_wdata, ent_rdata;
  logic          lowm_we;
  logic [VW-1:0] lowm_waddr, lowm_raddr, lowm_wdata, lowm_rdata;
  logic          parm_we;
  logic [VW-1:0] parm_waddr, parm_raddr;
  logic [LW-1:0] parm_wdata, parm_rdata;
  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [VW+PW-1:0] stk_wdata, stk_rdata;

  // Decoded conditions
  logic          in_acc;
  logic [CW-1:0] n_use;
  logic          add_full, add_bad, q_absent, ends_stale;
  logic [VW-1:0] adj_w, stk_v;
  logic [EW-1:0] adj_e;
  logic [PW-1:0] stk_pos;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != gbf_pkg::S_IDLE) || out_valid_r;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_assigned_edge = out_assigned_r;
  assign out_is_bridge     = out_bridge_r;
  assign out_bridge_count  = out_count_r;

  // Vertex count in use, capped at capacity
  always_comb begin
    if (32'(vcount_r) > 32'(MAX_VERTICES)) begin
      n_use = CW'(MAX_VERTICES);
    end else begin
      n_use = CW'(vcount_r);
    end
  end

  assign add_full   = 32'(loaded_r) >= 32'(MAX_EDGES);
  assign add_bad    = (32'(in_end_a) >= 32'(n_use)) || (32'(in_end_b) >= 32'(n_use));
  assign q_absent   = 32'(in_query_edge) >= 32'(loaded_r);
  assign ends_stale = (32'(ea_rdata) >= 32'(n_use)) || (32'(eb_rdata) >= 32'(n_use));
  assign adj_w      = adj_rdata[VW+EW-1:EW];
  assign adj_e      = adj_rdata[EW-1:0];
  assign stk_v      = stk_rdata[VW+PW-1:PW];
  assign stk_pos    = stk_rdata[PW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbf_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == gbf_pkg::REQ_RUN) begin
            state_nxt = gbf_pkg::S_CLR;
          end else if (in_req_type == gbf_pkg::REQ_QUERY && !q_absent) begin
            state_nxt = gbf_pkg::S_QRY;
          end
        end
      end
      gbf_pkg::S_QRY:    state_nxt = gbf_pkg::S_IDLE;
      gbf_pkg::S_CLR: begin
        if (vcnt_r == n_use) state_nxt = gbf_pkg::S_DEG_RD;
      end
      gbf_pkg::S_DEG_RD: begin
        state_nxt = (ecnt_r == loaded_r) ? gbf_pkg::S_PRE_RD : gbf_pkg::S_DEG_A;
      end
      gbf_pkg::S_DEG_A:  state_nxt = ends_stale ? gbf_pkg::S_DEG_RD : gbf_pkg::S_DEG_AW;
      gbf_pkg::S_DEG_AW: state_nxt = gbf_pkg::S_DEG_BR;
      gbf_pkg::S_DEG_BR: state_nxt = gbf_pkg::S_DEG_BW;
      gbf_pkg::S_DEG_BW: state_nxt = gbf_pkg::S_DEG_RD;
      gbf_pkg::S_PRE_RD: begin
        state_nxt = (vcnt_r == n_use) ? gbf_pkg::S_PRE_END : gbf_pkg::S_PRE_WR;
      end
      gbf_pkg::S_PRE_WR:  state_nxt = gbf_pkg::S_PRE_RD;
      gbf_pkg::S_PRE_END: state_nxt = gbf_pkg::S_FIL_RD;
      gbf_pkg::S_FIL_RD: begin
        state_nxt = (ecnt_r == loaded_r) ? gbf_pkg::S_ROOT : gbf_pkg::S_FIL_A;
      end
      gbf_pkg::S_FIL_A:  state_nxt = ends_stale ? gbf_pkg::S_FIL_RD : gbf_pkg::S_FIL_AW;
      gbf_pkg::S_FIL_AW: state_nxt = gbf_pkg::S_FIL_BR;
      gbf_pkg::S_FIL_BR: state_nxt = gbf_pkg::S_FIL_BW;
      gbf_pkg::S_FIL_BW: state_nxt = gbf_pkg::S_FIL_RD;
      gbf_pkg::S_ROOT: begin
        state_nxt = (root_r == n_use) ? gbf_pkg::S_DONE : gbf_pkg::S_ROOT_CHK;
      end
      gbf_pkg::S_ROOT_CHK: state_nxt = vis_rdata ? gbf_pkg::S_ROOT : gbf_pkg::S_ENT_RD0;
      gbf_pkg::S_ENT_RD0:  state_nxt = gbf_pkg::S_ENT_RD1;
      gbf_pkg::S_ENT_RD1:  state_nxt = gbf_pkg::S_ENT_SET;
      gbf_pkg::S_ENT_SET:  state_nxt = gbf_pkg::S_TOP;
      gbf_pkg::S_TOP: begin
        if (pos_r < end_r) begin
          state_nxt = gbf_pkg::S_ADJ;
        end else if (depth_r > CW'(1)) begin
          state_nxt = gbf_pkg::S_POP_RD;
        end else begin
          state_nxt = gbf_pkg::S_ROOT;
        end
      end
      gbf_pkg::S_ADJ: begin
        state_nxt = (LW'(adj_e) == par_r) ? gbf_pkg::S_TOP : gbf_pkg::S_VIS;
      end
      gbf_pkg::S_VIS:     state_nxt = vis_rdata ? gbf_pkg::S_TOP : gbf_pkg::S_ENT_RD0;
      gbf_pkg::S_POP_RD:  state_nxt = gbf_pkg::S_POP_SET;
      gbf_pkg::S_POP_SET: state_nxt = gbf_pkg::S_TOP;
      gbf_pkg::S_DONE:    state_nxt = gbf_pkg::S_IDLE;
      default:            state_nxt = gbf_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result word
  always_comb begin
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_assigned_nxt = out_assigned_r;
    out_bridge_nxt   = out_bridge_r;
    out_count_nxt    = out_count_r;
    loaded_nxt  = loaded_r;
    bridges_nxt = bridges_r;
    q_nxt       = q_r;
    vcnt_nxt    = vcnt_r;
    ecnt_nxt    = ecnt_r;
    total_nxt   = total_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    root_nxt    = root_r;
    timer_nxt   = timer_r;
    depth_nxt   = depth_r;
    v_nxt       = v_r;
    w_nxt       = w_r;
    u_nxt       = u_r;
    pos_nxt     = pos_r;
    end_nxt     = end_r;
    wstart_nxt  = wstart_r;
    upos_nxt    = upos_r;
    low_nxt     = low_r;
    par_nxt     = par_r;
    e_nxt       = e_r;

    edge_we = 1'b0; edge_waddr = '0; edge_raddr = '0; ea_wdata = '0; eb_wdata = '0;
    flag_we = 1'b0; flag_waddr = '0; flag_raddr = '0; flag_wdata = 1'b0;
    start_we = 1'b0; start_waddr = '0; start_raddr = '0; start_wdata = '0;
    fill_we = 1'b0; fill_waddr = '0; fill_raddr = '0; fill_wdata = '0;
    adj_we = 1'b0; adj_waddr = '0; adj_raddr = '0; adj_wdata = '0;
    vis_we = 1'b0; vis_waddr = '0; vis_raddr = '0; vis_wdata = 1'b0;
    ent_we = 1'b0; ent_waddr = '0; ent_raddr = '0; ent_wdata = '0;
    lowm_we = 1'b0; lowm_waddr = '0; lowm_raddr = '0; lowm_wdata = '0;
    parm_we = 1'b0; parm_waddr = '0; parm_raddr = '0; parm_wdata = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_raddr = '0; stk_wdata = '0;

    case (state_r)
      // Request decode
      gbf_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            gbf_pkg::REQ_CLEAR: begin
              loaded_nxt       = '0;
              bridges_nxt      = '0;
              out_valid_nxt    = 1'b1;
              out_status_nxt   = gbf_pkg::ST_OK;
              out_assigned_nxt = '0;
              out_bridge_nxt   = 1'b0;
              out_count_nxt    = '0;
            end
            gbf_pkg::REQ_ADD: begin
              out_valid_nxt    = 1'b1;
              out_assigned_nxt = '0;
              out_bridge_nxt   = 1'b0;
              out_count_nxt    = bridges_r;
              if (add_full) begin
                out_status_nxt = gbf_pkg::ST_FULL;
              end else if (add_bad) begin
                out_status_nxt = gbf_pkg::ST_BADVTX;
              end else begin
                edge_we          = 1'b1;
                edge_waddr       = EW'(loaded_r);
                ea_wdata         = VW'(in_end_a);
                eb_wdata         = VW'(in_end_b);
                flag_we          = 1'b1;
                flag_waddr       = EW'(loaded_r);
                flag_wdata       = 1'b0;
                loaded_nxt       = loaded_r + LW'(1);
                out_status_nxt   = gbf_pkg::ST_OK;
                out_assigned_nxt = gbf_pkg::QEDGE_W'(loaded_r);
              end
            end
            gbf_pkg::REQ_RUN: begin
              bridges_nxt = '0;
              vcnt_nxt    = '0;
            end
            gbf_pkg::REQ_QUERY: begin
              q_nxt      = in_query_edge;
              flag_raddr = EW'(in_query_edge);
              if (q_absent) begin
                out_valid_nxt    = 1'b1;
                out_status_nxt   = gbf_pkg::ST_NOTLOAD;
                out_assigned_nxt = in_query_edge;
                out_bridge_nxt   = 1'b0;
                out_count_nxt    = bridges_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gbf_pkg::S_QRY: begin
        out_valid_nxt    = 1'b1;
        out_status_nxt   = gbf_pkg::ST_OK;
        out_assigned_nxt = q_r;
        out_bridge_nxt   = flag_rdata;
        out_count_nxt    = bridges_r;
      end
      // Zero degree counters and visited marks
      gbf_pkg::S_CLR: begin
        start_we    = 1'b1;
        start_waddr = vcnt_r;
        start_wdata = '0;
        if (vcnt_r < n_use) begin
          vis_we    = 1'b1;
          vis_waddr = VW'(vcnt_r);
          vis_wdata = 1'b0;
        end
        if (vcnt_r == n_use) begin
          ecnt_nxt = '0;
        end else begin
          vcnt_nxt = vcnt_r + CW'(1);
        end
      end
      // Degree count; bridge flags of loaded edges cleared on the way
      gbf_pkg::S_DEG_RD: begin
        if (ecnt_r == loaded_r) begin
          vcnt_nxt  = '0;
          total_nxt = '0;
        end else begin
          edge_raddr = EW'(ecnt_r);
          flag_we    = 1'b1;
          flag_waddr = EW'(ecnt_r);
          flag_wdata = 1'b0;
        end
      end
      gbf_pkg::S_DEG_A: begin
        a_nxt = ea_rdata;
        b_nxt = eb_rdata;
        if (ends_stale) begin
          ecnt_nxt = ecnt_r + LW'(1);
        end else begin
          start_raddr = CW'(ea_rdata);
        end
      end
      gbf_pkg::S_DEG_AW: begin
        start_we    = 1'b1;
        start_waddr = CW'(a_r);
        start_wdata = start_rdata + PW'(1);
      end
      gbf_pkg::S_DEG_BR: start_raddr = CW'(b_r);
      gbf_pkg::S_DEG_BW: begin
        start_we    = 1'b1;
        start_waddr = CW'(b_r);
        start_wdata = start_rdata + PW'(1);
        ecnt_nxt    = ecnt_r + LW'(1);
      end
      // Prefix sum into list starts and fill pointers
      gbf_pkg::S_PRE_RD: begin
        if (vcnt_r != n_use) start_raddr = vcnt_r;
      end
      gbf_pkg::S_PRE_WR: begin
        start_we    = 1'b1;
        start_waddr = vcnt_r;
        start_wdata = total_r;
        fill_we     = 1'b1;
        fill_waddr  = VW'(vcnt_r);
        fill_wdata  = total_r;
        total_nxt   = total_r + start_rdata;
        vcnt_nxt    = vcnt_r + CW'(1);
      end
      gbf_pkg::S_PRE_END: begin
        start_we    = 1'b1;
        start_waddr = n_use;
        start_wdata = total_r;
        ecnt_nxt    = '0;
      end
      // Fill adjacency lists
      gbf_pkg::S_FIL_RD: begin
        if (ecnt_r == loaded_r) begin
          root_nxt  = '0;
          timer_nxt = '0;
          depth_nxt = '0;
        end else begin
          edge_raddr = EW'(ecnt_r);
        end
      end
      gbf_pkg::S_FIL_A: begin
        a_nxt = ea_rdata;
        b_nxt = eb_rdata;
        if (ends_stale) begin
          ecnt_nxt = ecnt_r + LW'(1);
        end else begin
          fill_raddr = ea_rdata;
        end
      end
      gbf_pkg::S_FIL_AW: begin
        adj_we     = 1'b1;
        adj_waddr  = XW'(fill_rdata);
        adj_wdata  = {b_r, EW'(ecnt_r)};
        fill_we    = 1'b1;
        fill_waddr = a_r;
        fill_wdata = fill_rdata + PW'(1);
      end
      gbf_pkg::S_FIL_BR: fill_raddr = b_r;
      gbf_pkg::S_FIL_BW: begin
        adj_we     = 1'b1;
        adj_waddr  = XW'(fill_rdata);
        adj_wdata  = {a_r, EW'(ecnt_r)};
        fill_we    = 1'b1;
        fill_waddr = b_r;
        fill_wdata = fill_rdata + PW'(1);
        ecnt_nxt   = ecnt_r + LW'(1);
      end
      // Root scan
      gbf_pkg::S_ROOT: begin
        if (root_r != n_use) vis_raddr = VW'(root_r);
      end
      gbf_pkg::S_ROOT_CHK: begin
        if (vis_rdata) begin
          root_nxt = root_r + CW'(1);
        end else begin
          w_nxt = VW'(root_r);
          e_nxt = NO_EDGE;
        end
      end
      // Enter vertex w by edge e
      gbf_pkg::S_ENT_RD0: start_raddr = CW'(w_r);
      gbf_pkg::S_ENT_RD1: begin
        wstart_nxt  = start_rdata;
        start_raddr = CW'(w_r) + CW'(1);
      end
      gbf_pkg::S_ENT_SET: begin
        vis_we     = 1'b1;
        vis_waddr  = w_r;
        vis_wdata  = 1'b1;
        ent_we     = 1'b1;
        ent_waddr  = w_r;
        ent_wdata  = timer_r;
        parm_we    = 1'b1;
        parm_waddr = w_r;
        parm_wdata = e_r;
        v_nxt      = w_r;
        pos_nxt    = wstart_r;
        end_nxt    = start_rdata;
        low_nxt    = timer_r;
        par_nxt    = e_r;
        timer_nxt  = timer_r + VW'(1);
        depth_nxt  = depth_r + CW'(1);
      end
      // Next neighbor of the top vertex, else pop, or move to the next root
      gbf_pkg::S_TOP: begin
        if (pos_r < end_r) begin
          adj_raddr = XW'(pos_r);
        end else if (depth_r > CW'(1)) begin
          stk_raddr = VW'(depth_r - CW'(2));
        end else begin
          depth_nxt = '0;
          root_nxt  = root_r + CW'(1);
        end
      end
      gbf_pkg::S_ADJ: begin
        w_nxt   = adj_w;
        e_nxt   = LW'(adj_e);
        pos_nxt = pos_r + PW'(1);
        if (LW'(adj_e) != par_r) begin
          vis_raddr = adj_w;
          ent_raddr = adj_w;
        end
      end
      // Back edge lowers low, else push the top and descend
      gbf_pkg::S_VIS: begin
        if (vis_rdata) begin
          if (ent_rdata < low_r) low_nxt = ent_rdata;
        end else begin
          stk_we     = 1'b1;
          stk_waddr  = VW'(depth_r - CW'(1));
          stk_wdata  = {v_r, pos_r};
          lowm_we    = 1'b1;
          lowm_waddr = v_r;
          lowm_wdata = low_r;
        end
      end
      gbf_pkg::S_POP_RD: begin
        u_nxt       = stk_v;
        upos_nxt    = stk_pos;
        lowm_raddr  = stk_v;
        ent_raddr   = stk_v;
        parm_raddr  = stk_v;
        start_raddr = CW'(stk_v) + CW'(1);
      end
      // Fold child into parent, test tree edge
      gbf_pkg::S_POP_SET: begin
        if ((low_r > ent_rdata) && (par_r != NO_EDGE)) begin
          flag_we    = 1'b1;
          flag_waddr = EW'(par_r);
          flag_wdata = 1'b1;
          if (bridges_r != gbf_pkg::CNT_MAX) bridges_nxt = bridges_r + gbf_pkg::CNT_W'(1);
        end
        v_nxt     = u_r;
        pos_nxt   = upos_r;
        end_nxt   = start_rdata;
        low_nxt   = (low_r < lowm_rdata) ? low_r : lowm_rdata;
        par_nxt   = parm_rdata;
        depth_nxt = depth_r - CW'(1);
      end
      gbf_pkg::S_DONE: begin
        out_valid_nxt    = 1'b1;
        out_status_nxt   = gbf_pkg::ST_OK;
        out_assigned_nxt = '0;
        out_bridge_nxt   = 1'b0;
        out_count_nxt    = bridges_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      vcount_r    <= gbf_pkg::CFG_W'(1);
      loaded_r    <= '0;
      bridges_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      loaded_r    <= loaded_nxt;
      bridges_r   <= bridges_nxt;
      if (cfg_wr_en) vcount_r <= cfg_vertex_count;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    out_status_r   <= out_status_nxt;
    out_assigned_r <= out_assigned_nxt;
    out_bridge_r   <= out_bridge_nxt;
    out_count_r    <= out_count_nxt;
    q_r      <= q_nxt;
    vcnt_r   <= vcnt_nxt;
    ecnt_r   <= ecnt_nxt;
    total_r  <= total_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    root_r   <= root_nxt;
    timer_r  <= timer_nxt;
    depth_r  <= depth_nxt;
    v_r      <= v_nxt;
    w_r      <= w_nxt;
    u_r      <= u_nxt;
    pos_r    <= pos_nxt;
    end_r    <= end_nxt;
    wstart_r <= wstart_nxt;
    upos_r   <= upos_nxt;
    low_r    <= low_nxt;
    par_r    <= par_nxt;
    e_r      <= e_nxt;
  end

  // Edge table
  gbf_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_edge_a (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(ea_wdata),
    .raddr(edge_raddr), .rdata(ea_rdata));
  gbf_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_edge_b (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(eb_wdata),
    .raddr(edge_raddr), .rdata(eb_rdata));
  gbf_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_flag (
    .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .raddr(flag_raddr), .rdata(flag_rdata));

  // Adjacency lists
  gbf_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES + 1)) u_start (
    .clk(clk), .we(start_we), .waddr(start_waddr), .wdata(start_wdata),
    .raddr(start_raddr), .rdata(start_rdata));
  gbf_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata));
  gbf_ram #(.WIDTH(VW + EW), .DEPTH(2 * MAX_EDGES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata));

  // Per-vertex search state and walk stack
  gbf_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata));
  gbf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata));
  gbf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_low (
    .clk(clk), .we(lowm_we), .waddr(lowm_waddr), .wdata(lowm_wdata),
    .raddr(lowm_raddr), .rdata(lowm_rdata));
  gbf_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_par (
    .clk(clk), .we(parm_we), .waddr(parm_waddr), .wdata(parm_wdata),
    .raddr(parm_raddr), .rdata(parm_rdata));
  gbf_ram #(.WIDTH(VW + PW), .DEPTH(MAX_VERTICES)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

endmodule

>>> design/gbf_checker.sv
`timescale 1ns / 1ps
`include "graph_bridge_finder_unit_macros.svh"

// Port-level checks of the bridge finder.
module gbf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_wr_en,
  input logic [gbf_pkg::CFG_W-1:0]    cfg_vertex_count,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [gbf_pkg::REQ_W-1:0]    in_req_type,
  input logic [gbf_pkg::VTX_W-1:0]    in_end_a,
  input logic [gbf_pkg::VTX_W-1:0]    in_end_b,
  input logic [gbf_pkg::QEDGE_W-1:0]  in_query_edge,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [gbf_pkg::STAT_W-1:0]   out_status,
  input logic [gbf_pkg::QEDGE_W-1:0]  out_assigned_edge,
  input logic                         out_is_bridge,
  input logic [gbf_pkg::CNT_W-1:0]    out_bridge_count
);

  // A stalled result word stays
  `GBF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped under stall")

  // A stalled result word keeps its value
  `GBF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_status) && $stable(out_assigned_edge) && $stable(out_is_bridge) && $stable(out_bridge_count), "stalled result word changed")

  // No request is taken while a result word waits
  `GBF_ASSERT_NOW(a_one_in_flight, in_valid && !in_stall, !out_valid, "request taken with a result pending")

  // Clear and add answer in the next cycle
  `GBF_ASSERT_NEXT(a_fast_reply, in_valid && !in_stall && (in_req_type == gbf_pkg::REQ_CLEAR || in_req_type == gbf_pkg::REQ_ADD), out_valid, "clear or add not answered next cycle")

endmodule

bind graph_bridge_finder_unit gbf_checker u_gbf_checker (.*);
